FILE: sv/gds_pkg.sv
// ----------------------------------------------------------------------------
// gds_pkg
// Operation codes, leap-test constants and month tables for the date stepper.
// ----------------------------------------------------------------------------
package gds_pkg;

	localparam int KIND_W  = 2;
	localparam int DAY_W   = 5;
	localparam int MONTH_W = 4;
	localparam int YEAR_W  = 16;
	localparam int ORD_W   = 9;

	localparam logic [KIND_W-1:0] KIND_NEXT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_PREV = 2'd1;
	localparam logic [KIND_W-1:0] KIND_DOY  = 2'd2;

	localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
	localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
	localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

	// y % 25 == 0  <=>  (y * inverse of 25 mod 2^16) mod 2^16 <= (2^16 - 1) / 25
	localparam logic [YEAR_W-1:0] INV25     = 16'd23593;
	localparam logic [YEAR_W-1:0] DIV25_MAX = 16'd2621;

	// Days in month m; zero for a month code that means nothing.
	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
		input logic leap);
		logic [DAY_W-1:0] len;
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
			4'd2:                                       len = leap ? 5'd29 : 5'd28;
			default:                                    len = 5'd0;
		endcase
		return len;
	endfunction

	// Days in the months before m within the same year.
	function automatic logic [ORD_W-1:0] days_before(input logic [MONTH_W-1:0] m,
		input logic leap);
		logic [ORD_W-1:0] base;
		case (m)
			4'd1:    base = 9'd0;
			4'd2:    base = 9'd31;
			4'd3:    base = 9'd59;
			4'd4:    base = 9'd90;
			4'd5:    base = 9'd120;
			4'd6:    base = 9'd151;
			4'd7:    base = 9'd181;
			4'd8:    base = 9'd212;
			4'd9:    base = 9'd243;
			4'd10:   base = 9'd273;
			4'd11:   base = 9'd304;
			4'd12:   base = 9'd334;
			default: base = 9'd0;
		endcase
		if (leap && (m > MONTH_FEB)) begin
			base = base + 9'd1;
		end
		return base;
	endfunction

endpackage

FILE: sv/gregorian_date_step_top.sv
// ----------------------------------------------------------------------------
// gregorian_date_step_top
// Gregorian next day / previous day / day of year, three-stage pipeline.
// Throughput: one transaction per cycle while out_ready is high; a stall holds full stages, empty ones still fill.
// Stages: multiply for the divide-by-25 test, leap and table lookups, result.
// Reset: arst_n clears the stage valid bits only; data registers are not reset.
// ----------------------------------------------------------------------------
module gregorian_date_step_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [gds_pkg::KIND_W-1:0]  kind,
	input  logic [gds_pkg::DAY_W-1:0]   day,
	input  logic [gds_pkg::MONTH_W-1:0] month,
	input  logic [gds_pkg::YEAR_W-1:0]  year,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [gds_pkg::DAY_W-1:0]   out_day,
	output logic [gds_pkg::MONTH_W-1:0] out_month,
	output logic [gds_pkg::YEAR_W-1:0]  out_year,
	output logic [gds_pkg::ORD_W-1:0]   ordinal,
	output logic                       invalid
);
	import gds_pkg::*;

	logic en_s1, en_s2, en_s3;

	// stage 1
	logic                v_s1;
	logic [KIND_W-1:0]   kind_s1;
	logic [DAY_W-1:0]    day_s1;
	logic [MONTH_W-1:0]  month_s1;
	logic [YEAR_W-1:0]   year_s1;
	logic [YEAR_W-1:0]   prod_s1;

	// stage 2
	logic                v_s2;
	logic [KIND_W-1:0]   kind_s2;
	logic [DAY_W-1:0]    day_s2;
	logic [MONTH_W-1:0]  month_s2;
	logic [YEAR_W-1:0]   year_s2;
	logic                inv_s2;
	logic [DAY_W-1:0]    len_s2;
	logic [DAY_W-1:0]    plen_s2;
	logic [ORD_W-1:0]    base_s2;

	// stage 3 (output)
	logic                v_s3;
	logic [DAY_W-1:0]    od_s3;
	logic [MONTH_W-1:0]  om_s3;
	logic [YEAR_W-1:0]   oy_s3;
	logic [ORD_W-1:0]    ord_s3;
	logic                inv_s3;

	// A stage takes new data when it is empty or its content moves on.
	assign en_s3    = !v_s3 || out_ready;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	// ---- stage 1: register the transaction, start the mod-25 test ----
	// only the product mod 2^16 is needed
	logic [YEAR_W-1:0] prod_c;
	assign prod_c = YEAR_W'(year * INV25);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			kind_s1  <= kind;
			day_s1   <= day;
			month_s1 <= month;
			year_s1  <= year;
			prod_s1  <= prod_c;
		end
	end

	// ---- stage 2: leap rule, validity and table lookups ----
	logic             div4, div16, div25, leap;
	logic [DAY_W-1:0] len_c;
	logic [MONTH_W-1:0] pmonth;
	logic             bad;

	always_comb begin
		div4   = (year_s1[1:0] == 2'd0);
		div16  = (year_s1[3:0] == 4'd0);
		div25  = (prod_s1 <= DIV25_MAX);
		// leap: by 4 and not by 100, or by 400
		leap   = (div4 && !div25) || (div16 && div25);
		len_c  = month_len(month_s1, leap);
		bad    = (len_c == '0) || (day_s1 == '0) || (day_s1 > len_c);
		pmonth = (month_s1 == MONTH_JAN) ? MONTH_DEC : (month_s1 - MONTH_JAN);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && v_s1) begin
			kind_s2  <= kind_s1;
			day_s2   <= day_s1;
			month_s2 <= month_s1;
			year_s2  <= year_s1;
			inv_s2   <= bad;
			len_s2   <= len_c;
			// previous month is in the same year unless it is December
			plen_s2  <= month_len(pmonth, leap);
			base_s2  <= days_before(month_s1, leap);
		end
	end

	// ---- stage 3: form the result ----
	logic [DAY_W-1:0]   od_c;
	logic [MONTH_W-1:0] om_c;
	logic [YEAR_W-1:0]  oy_c;
	logic [ORD_W-1:0]   ord_c;

	always_comb begin
		od_c  = '0;
		om_c  = '0;
		oy_c  = '0;
		ord_c = '0;
		if (inv_s2) begin
			// all fields stay zero
		end else if (kind_s2[1]) begin
			ord_c = base_s2 + ORD_W'(day_s2);
		end else if (kind_s2 == KIND_NEXT) begin
			if (day_s2 == len_s2) begin
				od_c = DAY_W'(1);
				if (month_s2 == MONTH_DEC) begin
					om_c = MONTH_JAN;
					oy_c = year_s2 + YEAR_W'(1);
				end else begin
					om_c = month_s2 + MONTH_W'(1);
					oy_c = year_s2;
				end
			end else begin
				od_c = day_s2 + DAY_W'(1);
				om_c = month_s2;
				oy_c = year_s2;
			end
		end else begin
			if (day_s2 == DAY_W'(1)) begin
				od_c = plen_s2;
				if (month_s2 == MONTH_JAN) begin
					om_c = MONTH_DEC;
					oy_c = year_s2 - YEAR_W'(1);
				end else begin
					om_c = month_s2 - MONTH_W'(1);
					oy_c = year_s2;
				end
			end else begin
				od_c = day_s2 - DAY_W'(1);
				om_c = month_s2;
				oy_c = year_s2;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en_s3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3 && v_s2) begin
			od_s3  <= od_c;
			om_s3  <= om_c;
			oy_s3  <= oy_c;
			ord_s3 <= ord_c;
			inv_s3 <= inv_s2;
		end
	end

	assign out_valid = v_s3;
	assign out_day   = od_s3;
	assign out_month = om_s3;
	assign out_year  = oy_s3;
	assign ordinal   = ord_s3;
	assign invalid   = inv_s3;

endmodule
